FILE: src/loser_tree_kway_merge_core_macros.svh
// Assertion macros for the loser tree merge core.
// Used by the top level only; no other dependencies.
`ifndef LOSER_TREE_KWAY_MERGE_CORE_MACROS_SVH
`define LOSER_TREE_KWAY_MERGE_CORE_MACROS_SVH

// same-cycle implication
`define LTKM_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LTKM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: src/ltkm_pkg.sv
// Shared types and constants of the loser tree merge core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ltkm_pkg;

   localparam int KEY_W  = 32;
   localparam int LANE_W = 4;
   localparam int CNT_W  = 5;
   localparam int OP_W   = 2;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [LANE_W-1:0] lane_type;
   typedef logic [CNT_W-1:0]  cnt_type;
   typedef logic [OP_W-1:0]   op_type;

   localparam op_type OP_LOAD  = 2'd0;
   localparam op_type OP_BUILD = 2'd1;
   localparam op_type OP_POP   = 2'd2;

endpackage

`default_nettype wire

FILE: src/loser_tree_kway_merge_core.sv
// Loser tree k-way merge core: lane heads in RAM, one shared key comparator
// stepped by a small sequencer. Depends on ltkm_pkg, ltkm_ram and the macro header.
// Load: written straight from idle. Build: winner read, key read and compare steps per internal node.
// Pop: one tree level per cycle through a read/read/compare pipe on the loser and key RAMs.
// Reset (synchronous): lane count 16, all lanes absent, no result pending.
`timescale 1ns / 1ps
`default_nettype none
`include "loser_tree_kway_merge_core_macros.svh"

module loser_tree_kway_merge_core
   import ltkm_pkg::*;
#(
   parameter int MAX_LANES = 16
) (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   input  wire op_type   req_op,
   input  wire lane_type req_lane,
   input  wire key_type  req_key,
   input  wire logic     req_present,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   output key_type       rsp_out_key,
   output lane_type      rsp_out_lane,
   output logic          rsp_out_valid,
   input  wire logic     csr_wr_en,
   input  wire cnt_type  csr_wr_data
);

   localparam int IDX_W      = $clog2(MAX_LANES);
   localparam int NW         = IDX_W + 1;
   localparam int SUM_W      = NW + 1;
   localparam int LANE_FOLDS = 8;

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_BLD_RD  = 3'd1;
   localparam logic [2:0] ST_BLD_KEY = 3'd2;
   localparam logic [2:0] ST_BLD_CMP = 3'd3;
   localparam logic [2:0] ST_POP     = 3'd4;
   localparam logic [2:0] ST_DONE    = 3'd5;

   // control state
   logic [2:0]           state_ff, state_in;
   cnt_type              num_lanes_ff, num_lanes_in;
   logic [MAX_LANES-1:0] pres_ff, pres_in;
   logic [MAX_LANES-1:0] loser_vld_ff, loser_vld_in;
   logic [IDX_W-1:0]     win_lane_ff, win_lane_in;
   logic                 k_vld_ff, k_vld_in;
   logic                 c_vld_ff, c_vld_in;
   logic                 rsp_valid_ff, rsp_valid_in;

   // payload state
   logic [IDX_W-1:0] m_ff, m_in;
   logic [IDX_W-1:0] k_m_ff, k_m_in;
   logic             k_lv_ff, k_lv_in;
   logic [IDX_W-1:0] c_m_ff, c_m_in;
   logic [IDX_W-1:0] c_l_ff, c_l_in;
   logic [IDX_W-1:0] w_ff, w_in;
   key_type          w_key_ff, w_key_in;
   logic             w_pres_ff, w_pres_in;
   logic [IDX_W-1:0] bl_ff, bl_in;
   logic [IDX_W-1:0] br_ff, br_in;
   logic [IDX_W-1:0] pop_lane_ff, pop_lane_in;
   logic             pop_valid_ff, pop_valid_in;
   key_type          rsp_key_ff, rsp_key_in;
   lane_type         rsp_lane_ff, rsp_lane_in;
   logic             rsp_ov_ff, rsp_ov_in;

   // RAM ports
   logic             key_wr_en;
   logic [IDX_W-1:0] key_wr_addr;
   key_type          key_wr_data;
   logic             keya_rd_en, keyb_rd_en;
   logic [IDX_W-1:0] keya_rd_addr, keyb_rd_addr;
   key_type          keya_rd, keyb_rd;
   logic             win_wr_en;
   logic [IDX_W-1:0] win_wr_data;
   logic             win_rd_en;
   logic [IDX_W-1:0] wina_rd_addr, winb_rd_addr;
   logic [IDX_W-1:0] wina_rd, winb_rd;
   logic             los_wr_en;
   logic [IDX_W-1:0] los_wr_addr, los_wr_data;
   logic             los_rd_en;
   logic [IDX_W-1:0] los_rd;

   // helpers
   logic [NW-1:0]    n_lanes;
   lane_type         lane_mod;
   logic [IDX_W-1:0] lane_idx;
   logic [SUM_W-1:0] m0_sum;
   logic [IDX_W-1:0] m_start;
   logic [NW-1:0]    left_node, right_node;
   key_type          cmp_rhs;
   logic             key_lt;
   logic             bld_l_wins;
   logic [IDX_W-1:0] bld_winner, bld_loser;
   logic [IDX_W-1:0] pop_l;
   logic             pop_beats;

   always_comb begin
      if (num_lanes_ff < CNT_W'(2)) begin
         n_lanes = NW'(2);
      end else if (32'(num_lanes_ff) > MAX_LANES) begin
         n_lanes = NW'(MAX_LANES);
      end else begin
         n_lanes = NW'(num_lanes_ff);
      end
   end

   always_comb begin
      lane_mod = req_lane;
      for (int i = 0; i < LANE_FOLDS; i++) begin
         if (32'(lane_mod) >= MAX_LANES) begin
            lane_mod = lane_mod - LANE_W'(MAX_LANES);
         end
      end
   end

   assign lane_idx   = IDX_W'(lane_mod);
   assign m0_sum     = SUM_W'(n_lanes) + SUM_W'(win_lane_ff);
   assign m_start    = IDX_W'(m0_sum >> 1);
   assign left_node  = {m_ff, 1'b0};
   assign right_node = {m_ff, 1'b1};

   // one key comparator shared by build and pop replay
   assign cmp_rhs    = (state_ff == ST_BLD_CMP) ? keyb_rd : w_key_ff;
   assign key_lt     = keya_rd < cmp_rhs;

   assign bld_l_wins = pres_ff[bl_ff] && (!pres_ff[br_ff] || key_lt);
   assign bld_winner = bld_l_wins ? bl_ff : br_ff;
   assign bld_loser  = bld_l_wins ? br_ff : bl_ff;

   assign pop_l     = k_lv_ff ? los_rd : '0;
   assign pop_beats = pres_ff[c_l_ff] && (!w_pres_ff || key_lt);

   always_comb begin
      state_in     = state_ff;
      num_lanes_in = csr_wr_en ? csr_wr_data : num_lanes_ff;
      pres_in      = pres_ff;
      loser_vld_in = loser_vld_ff;
      win_lane_in  = win_lane_ff;
      k_vld_in     = 1'b0;
      c_vld_in     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      m_in         = m_ff;
      k_m_in       = k_m_ff;
      k_lv_in      = k_lv_ff;
      c_m_in       = c_m_ff;
      c_l_in       = c_l_ff;
      w_in         = w_ff;
      w_key_in     = w_key_ff;
      w_pres_in    = w_pres_ff;
      bl_in        = bl_ff;
      br_in        = br_ff;
      pop_lane_in  = pop_lane_ff;
      pop_valid_in = pop_valid_ff;
      rsp_key_in   = rsp_key_ff;
      rsp_lane_in  = rsp_lane_ff;
      rsp_ov_in    = rsp_ov_ff;

      key_wr_en    = 1'b0;
      key_wr_addr  = lane_idx;
      key_wr_data  = req_key;
      keya_rd_en   = 1'b0;
      keya_rd_addr = pop_l;
      keyb_rd_en   = 1'b0;
      keyb_rd_addr = win_lane_ff;
      win_wr_en    = 1'b0;
      win_wr_data  = bld_winner;
      win_rd_en    = 1'b0;
      wina_rd_addr = IDX_W'(left_node);
      winb_rd_addr = IDX_W'(right_node);
      los_wr_en    = 1'b0;
      los_wr_addr  = m_ff;
      los_wr_data  = bld_loser;
      los_rd_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_op)
                  OP_LOAD: begin
                     key_wr_en         = 1'b1;
                     pres_in[lane_idx] = req_present;
                  end
                  OP_BUILD: begin
                     m_in     = IDX_W'(n_lanes - NW'(1));
                     state_in = ST_BLD_RD;
                  end
                  OP_POP: begin
                     pop_lane_in = win_lane_ff;
                     if (pres_ff[win_lane_ff]) begin
                        key_wr_en            = 1'b1;
                        key_wr_addr          = win_lane_ff;
                        keyb_rd_en           = 1'b1;
                        pres_in[win_lane_ff] = req_present;
                        w_in                 = win_lane_ff;
                        w_key_in             = req_key;
                        w_pres_in            = req_present;
                        m_in                 = m_start;
                        pop_valid_in         = 1'b1;
                        state_in             = ST_POP;
                     end else begin
                        pop_valid_in = 1'b0;
                        state_in     = ST_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_BLD_RD: begin
            win_rd_en = 1'b1;
            state_in  = ST_BLD_KEY;
         end
         ST_BLD_KEY: begin
            bl_in        = (left_node >= n_lanes) ? IDX_W'(left_node - n_lanes) : wina_rd;
            br_in        = (right_node >= n_lanes) ? IDX_W'(right_node - n_lanes) : winb_rd;
            keya_rd_en   = 1'b1;
            keya_rd_addr = bl_in;
            keyb_rd_en   = 1'b1;
            keyb_rd_addr = br_in;
            state_in     = ST_BLD_CMP;
         end
         ST_BLD_CMP: begin
            win_wr_en          = 1'b1;
            los_wr_en          = 1'b1;
            loser_vld_in[m_ff] = 1'b1;
            if (m_ff == IDX_W'(1)) begin
               win_lane_in = bld_winner;
               state_in    = ST_IDLE;
            end else begin
               m_in     = m_ff - IDX_W'(1);
               state_in = ST_BLD_RD;
            end
         end
         ST_POP: begin
            // issue: read the stored loser of the next node up the path
            if (m_ff != '0) begin
               los_rd_en = 1'b1;
               k_vld_in  = 1'b1;
               k_m_in    = m_ff;
               k_lv_in   = loser_vld_ff[m_ff];
               m_in      = m_ff >> 1;
            end
            // fetch the loser's key
            if (k_vld_ff) begin
               keya_rd_en = 1'b1;
               c_vld_in   = 1'b1;
               c_l_in     = pop_l;
               c_m_in     = k_m_ff;
            end
            // replay the match
            if (c_vld_ff && pop_beats) begin
               los_wr_en            = 1'b1;
               los_wr_addr          = c_m_ff;
               los_wr_data          = w_ff;
               loser_vld_in[c_m_ff] = 1'b1;
               w_in                 = c_l_ff;
               w_key_in             = keya_rd;
               w_pres_in            = 1'b1;
            end
            if (m_ff == '0 && !k_vld_ff && !c_vld_ff) begin
               win_lane_in = w_ff;
               state_in    = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_ov_in    = pop_valid_ff;
               rsp_key_in   = pop_valid_ff ? keyb_rd : '0;
               rsp_lane_in  = pop_valid_ff ? LANE_W'(pop_lane_ff) : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         num_lanes_ff <= CNT_W'(16);
         pres_ff      <= '0;
         loser_vld_ff <= '0;
         win_lane_ff  <= '0;
         k_vld_ff     <= 1'b0;
         c_vld_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         num_lanes_ff <= num_lanes_in;
         pres_ff      <= pres_in;
         loser_vld_ff <= loser_vld_in;
         win_lane_ff  <= win_lane_in;
         k_vld_ff     <= k_vld_in;
         c_vld_ff     <= c_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      m_ff         <= m_in;
      k_m_ff       <= k_m_in;
      k_lv_ff      <= k_lv_in;
      c_m_ff       <= c_m_in;
      c_l_ff       <= c_l_in;
      w_ff         <= w_in;
      w_key_ff     <= w_key_in;
      w_pres_ff    <= w_pres_in;
      bl_ff        <= bl_in;
      br_ff        <= br_in;
      pop_lane_ff  <= pop_lane_in;
      pop_valid_ff <= pop_valid_in;
      rsp_key_ff   <= rsp_key_in;
      rsp_lane_ff  <= rsp_lane_in;
      rsp_ov_ff    <= rsp_ov_in;
   end

   ltkm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LANES)) u_key_a (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (keya_rd_en),
      .rd_addr (keya_rd_addr),
      .rd_data (keya_rd)
   );

   ltkm_ram #(.WIDTH(KEY_W), .DEPTH(MAX_LANES)) u_key_b (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (key_wr_data),
      .rd_en   (keyb_rd_en),
      .rd_addr (keyb_rd_addr),
      .rd_data (keyb_rd)
   );

   ltkm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LANES)) u_win_a (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (m_ff),
      .wr_data (win_wr_data),
      .rd_en   (win_rd_en),
      .rd_addr (wina_rd_addr),
      .rd_data (wina_rd)
   );

   ltkm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LANES)) u_win_b (
      .clock   (clock),
      .wr_en   (win_wr_en),
      .wr_addr (m_ff),
      .wr_data (win_wr_data),
      .rd_en   (win_rd_en),
      .rd_addr (winb_rd_addr),
      .rd_data (winb_rd)
   );

   ltkm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_LANES)) u_loser (
      .clock   (clock),
      .wr_en   (los_wr_en),
      .wr_addr (los_wr_addr),
      .wr_data (los_wr_data),
      .rd_en   (los_rd_en),
      .rd_addr (m_ff),
      .rd_data (los_rd)
   );

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_key   = rsp_key_ff;
   assign rsp_out_lane  = rsp_lane_ff;
   assign rsp_out_valid = rsp_ov_ff;

   `LTKM_ASSERT_NEXT(a_pop_goes_busy, clock, reset,
                     req_valid && req_ready && (req_op == OP_POP), !req_ready,
                     "pop beat accepted but core stayed ready")
   `LTKM_ASSERT_IMPLIES(a_rsp_from_done, clock, reset, $rose(rsp_valid),
                        $past(state_ff) == ST_DONE, "result beat raised outside the done step")
   `LTKM_ASSERT_NEXT(a_no_rsp_for_nonpop, clock, reset,
                     req_valid && req_ready && (req_op != OP_POP), !$rose(rsp_valid),
                     "result beat raised for a load or build")
   `LTKM_ASSERT_IMPLIES(a_pipe_in_pop, clock, reset, k_vld_ff || c_vld_ff,
                        state_ff == ST_POP, "replay pipe active outside a pop")

endmodule

`default_nettype wire

FILE: src/ltkm_ram.sv
// Generic RAM: one write port, one read port with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ltkm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: dv/loser_tree_kway_merge_core_tb.sv
// Self-checking testbench for loser_tree_kway_merge_core: load/build/pop beats with
// random gaps and stalls, checked against an in-bench loser tree predictor.
// Depends on ltkm_pkg and the core RTL only.
`timescale 1ns / 1ps

module loser_tree_kway_merge_core_tb;
   import ltkm_pkg::*;

   localparam int LANES = 16;
   localparam int DRAIN_CYCLES = 64;
   localparam int HOLD_CYCLES = 300;
   localparam int RANDOM_BEATS = 800;
   localparam op_type OP_UNUSED = 2'd3;

   typedef struct {
      op_type   op;
      lane_type lane;
      key_type  key;
      logic     present;
   } req_beat_type;

   typedef struct {
      key_type  out_key;
      lane_type out_lane;
      logic     out_valid;
   } merge_out_type;

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     req_valid = 1'b0;
   logic     req_ready;
   op_type   req_op = OP_LOAD;
   lane_type req_lane = '0;
   key_type  req_key = '0;
   logic     req_present = 1'b0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   key_type  rsp_out_key;
   lane_type rsp_out_lane;
   logic     rsp_out_valid;
   logic     csr_wr_en = 1'b0;
   cnt_type  csr_wr_data = '0;

   req_beat_type  req_beats_q[$];
   merge_out_type emitted_q[$];

   // predictor state
   key_type  head_key [LANES];
   bit       head_on [LANES];
   lane_type loser_slot [LANES];
   cnt_type  lanes_cfg = cnt_type'(LANES);

   bit steady = 1'b0;
   int holds_req = 0;
   int holds_seen = 0;
   int stall_left = 0;
   int errors = 0;
   int beats_in = 0;
   int pops_checked = 0;
   int pops_dry = 0;
   int stim_count = 0;
   int settings_run = 0;

   loser_tree_kway_merge_core #(.MAX_LANES(LANES)) u_dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_op       (req_op),
      .req_lane     (req_lane),
      .req_key      (req_key),
      .req_present  (req_present),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_out_key  (rsp_out_key),
      .rsp_out_lane (rsp_out_lane),
      .rsp_out_valid(rsp_out_valid),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data)
   );

   always #1 clock = ~clock;

   initial begin
      foreach (head_on[i]) begin
         head_on[i] = 1'b0;
         head_key[i] = '0;
         loser_slot[i] = '0;
      end
   end

   function automatic int eff_lanes(input cnt_type v);
      if (v < 2) return 2;
      if (v > LANES) return LANES;
      return int'(v);
   endfunction

   function automatic bit beats_lane(input lane_type a, input lane_type b);
      if (!head_on[a]) return 1'b0;
      if (!head_on[b]) return 1'b1;
      return head_key[a] < head_key[b];
   endfunction

   function automatic void rebuild_tree();
      lane_type champ [LANES];
      lane_type a;
      lane_type b;
      int n;
      int l;
      int r;
      n = eff_lanes(lanes_cfg);
      foreach (champ[i]) champ[i] = '0;
      for (int m = n - 1; m > 0; m--) begin
         l = 2 * m;
         r = 2 * m + 1;
         a = (l >= n) ? lane_type'(l - n) : champ[l];
         b = (r >= n) ? lane_type'(r - n) : champ[r];
         if (beats_lane(a, b)) begin
            champ[m] = a;
            loser_slot[m] = b;
         end else begin
            champ[m] = b;
            loser_slot[m] = a;
         end
      end
      loser_slot[0] = champ[1];
   endfunction

   function automatic void merge_step(input req_beat_type bt);
      lane_type p;
      lane_type w;
      lane_type l;
      int m;
      merge_out_type res;
      case (bt.op)
         OP_LOAD: begin
            head_key[bt.lane] = bt.key;
            head_on[bt.lane] = bt.present;
         end
         OP_BUILD: rebuild_tree();
         OP_POP: begin
            p = loser_slot[0];
            if (!head_on[p]) begin
               res = '{out_key: '0, out_lane: '0, out_valid: 1'b0};
               emitted_q = {emitted_q, res};
            end else begin
               res = '{out_key: head_key[p], out_lane: p, out_valid: 1'b1};
               emitted_q = {emitted_q, res};
               head_key[p] = bt.key;
               head_on[p] = bt.present;
               w = p;
               m = ((int'(p) + eff_lanes(lanes_cfg)) / 2) % LANES;
               while (m > 0) begin
                  l = loser_slot[m];
                  if (beats_lane(l, w)) begin
                     loser_slot[m] = w;
                     w = l;
                  end
                  m = m / 2;
               end
               loser_slot[0] = w;
            end
         end
         default: ;
      endcase
   endfunction

   // driver
   always @(posedge clock) begin
      req_beat_type bt;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_beats_q.size() != 0 && (steady || $urandom_range(99) >= 29)) begin
            bt = req_beats_q.pop_front();
            req_valid <= 1'b1;
            req_op <= bt.op;
            req_lane <= bt.lane;
            req_key <= bt.key;
            req_present <= bt.present;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left <= 0;
      end else if (holds_seen != holds_req) begin
         holds_seen <= holds_req;
         stall_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= steady || ($urandom_range(99) >= 29);
      end
   end

   // monitor: predict on accepted requests, check accepted results
   always @(posedge clock) begin
      merge_out_type want;
      req_beat_type bt;
      if (!reset) begin
         if (csr_wr_en) lanes_cfg = csr_wr_data;
         if (req_valid && req_ready) begin
            bt = '{op: req_op, lane: req_lane, key: req_key, present: req_present};
            merge_step(bt);
            beats_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (emitted_q.size() == 0) begin
               $display("%0t unexpected result: key %h lane %0d valid %b", $time,
                        rsp_out_key, rsp_out_lane, rsp_out_valid);
               errors++;
            end else begin
               want = emitted_q.pop_front();
               pops_checked++;
               if (!want.out_valid) pops_dry++;
               if (rsp_out_key !== want.out_key) begin
                  $display("%0t out_key mismatch: expected %h, actual %h", $time,
                           want.out_key, rsp_out_key);
                  errors++;
               end
               if (rsp_out_lane !== want.out_lane) begin
                  $display("%0t out_lane mismatch: expected %0d, actual %0d", $time,
                           want.out_lane, rsp_out_lane);
                  errors++;
               end
               if (rsp_out_valid !== want.out_valid) begin
                  $display("%0t out_valid mismatch: expected %b, actual %b", $time,
                           want.out_valid, rsp_out_valid);
                  errors++;
               end
            end
         end
      end
   end

   function automatic void add_beat(input op_type op, input int lane, input key_type key,
                                    input logic present);
      req_beat_type bt;
      bt = '{op: op, lane: lane_type'(lane), key: key, present: present};
      req_beats_q = {req_beats_q, bt};
      if (op != OP_UNUSED) stim_count++;
   endfunction

   function automatic key_type draw_key(input key_type base);
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return '1;
         2: return '0;
         default: return base + key_type'($urandom_range(0, 15));
      endcase
   endfunction

   // one merge: load heads, build, pop with refills, some noise mixed in
   function automatic void queue_merge(input int n);
      key_type base;
      int pops;
      base = ($urandom_range(0, 3) == 0) ? key_type'($urandom()) :
                                           key_type'($urandom_range(0, 1000));
      for (int i = 0; i < n; i++)
         add_beat(OP_LOAD, i, draw_key(base), $urandom_range(0, 9) != 0);
      if ($urandom_range(0, 3) == 0)
         add_beat(OP_LOAD, $urandom_range(n % LANES, LANES - 1), $urandom(),
                  1'($urandom_range(0, 1)));
      add_beat(OP_BUILD, $urandom_range(0, LANES - 1), $urandom(),
               1'($urandom_range(0, 1)));
      pops = 2 * n + $urandom_range(0, n);
      for (int i = 0; i < pops; i++) begin
         case ($urandom_range(0, 24))
            0: add_beat(OP_UNUSED, $urandom_range(0, LANES - 1), $urandom(),
                        1'($urandom_range(0, 1)));
            1: add_beat(OP_LOAD, $urandom_range(0, LANES - 1), draw_key(base),
                        1'($urandom_range(0, 1)));
            default: ;
         endcase
         add_beat(OP_POP, $urandom_range(0, LANES - 1), draw_key(base + key_type'(8 * i)),
                  $urandom_range(0, 5) != 0);
      end
   endfunction

   task automatic wait_quiet();
      do @(negedge clock);
      while (req_beats_q.size() != 0 || req_valid || emitted_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_lanes(input cnt_type v);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      settings_run++;
   endtask

   initial begin
      cnt_type setting;
      int phase;
      int n;
      int goal;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      set_lanes(cnt_type'(LANES));
      @(negedge clock);
      // first build runs at full width so every tree slot is defined
      add_beat(OP_LOAD, 0, 32'h0000_0000, 1'b1);
      add_beat(OP_LOAD, 15, 32'hFFFF_FFFF, 1'b1);
      add_beat(OP_LOAD, 5, 32'h8000_0000, 1'b1);
      add_beat(OP_LOAD, 10, 32'h8000_0000, 1'b1);
      add_beat(OP_LOAD, 3, 32'h5555_5555, 1'b0);
      add_beat(OP_LOAD, 12, 32'hAAAA_AAAA, 1'b1);
      add_beat(OP_BUILD, 0, 32'h0, 1'b0);
      add_beat(OP_POP, 15, 32'h0000_0000, 1'b1);
      add_beat(OP_POP, 0, 32'hFFFF_FFFF, 1'b0);
      for (int i = 0; i < 6; i++) add_beat(OP_POP, i, 32'h0, 1'b0);
      add_beat(OP_POP, 9, 32'h1234_5678, 1'b1);
      add_beat(OP_UNUSED, 6, 32'hDEAD_BEEF, 1'b1);
      add_beat(OP_BUILD, 15, 32'hFFFF_FFFF, 1'b1);
      add_beat(OP_POP, 0, 32'h0, 1'b1);
      add_beat(OP_LOAD, 7, 32'h0000_0001, 1'b1);
      add_beat(OP_LOAD, 8, 32'h0000_0001, 1'b1);
      add_beat(OP_BUILD, 0, 32'h0, 1'b0);
      for (int i = 0; i < 3; i++) add_beat(OP_POP, 0, 32'h0, 1'b0);
      wait_quiet();
      stim_count = 0;

      phase = 0;
      while (stim_count < RANDOM_BEATS) begin
         case (phase)
            0: setting = 5'd2;
            1: setting = 5'd16;
            2: setting = cnt_type'($urandom_range(2, 16));
            3: setting = 5'd0;
            4: setting = 5'd31;
            5: setting = 5'd1;
            6: setting = cnt_type'($urandom_range(3, 15));
            default: setting = cnt_type'($urandom_range(0, 31));
         endcase
         set_lanes(setting);
         n = eff_lanes(setting);
         @(negedge clock);
         steady = (phase == 2);
         if (phase == 1 || phase == 4) holds_req++;
         // pop on the tree left from the previous lane count
         if ($urandom_range(0, 1))
            for (int i = 0; i < $urandom_range(1, 3); i++)
               add_beat(OP_POP, $urandom_range(0, LANES - 1), $urandom(),
                        1'($urandom_range(0, 1)));
         goal = stim_count + 100;
         while (stim_count < goal) queue_merge(n);
         wait_quiet();
         phase++;
      end

      $display("Summary: %0d request beats, %0d pops checked (%0d with every lane dry),",
               beats_in, pops_checked, pops_dry);
      $display("         %0d lane-count settings incl. clamped values, %0d mismatches",
               settings_run, errors);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #1_500_000;
      $display("%0t timeout with %0d results outstanding", $time, emitted_q.size());
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
